/* sv/lbc_pkg.sv */
package lbc_pkg;

    localparam int MAX_ENTRIES     = 256;
    localparam int BLOCK_WORDS     = 32;
    localparam int NUM_DISKS       = 16;
    localparam int BLOCKS_PER_DISK = 256;
    localparam int MIN_CAP         = 2;

    localparam int ENTRY_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W  = 5;
    localparam int DADDR_W = ENTRY_W + WORD_W;

    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(BLOCK_WORDS - 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_DISABLED = 3'd2,
        ST_RANGE    = 3'd3,
        ST_UPDATED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        KIND_LKP_OFF,
        KIND_LKP,
        KIND_INS_FIRST,
        KIND_INS_WORD,
        KIND_INS_SKIP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        status_t     check;
        logic [3:0]  disk;
        logic [7:0]  blk;
        logic [WORD_W-1:0] word;
        logic [63:0] data;
    } lbc_item_t;

    typedef struct packed {
        logic             on;
        logic [CNT_W-1:0] cap;
        logic             clear;
    } lbc_cfg_t;

endpackage

/* sv/lbc_front.sv */
module lbc_front
    import lbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lbc_cfg_t    cfg,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [3:0]  disk,
    input  logic [7:0]  block_index,
    input  logic [4:0]  word_index,
    input  logic [63:0] data_in,
    input  logic        q_pop,
    output logic        q_empty,
    output lbc_item_t   q_item
);

    lbc_item_t  q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    lbc_item_t  cls;
    logic       do_push, do_pop;

    // classify on entry
    always_comb
    begin
        cls.disk  = disk;
        cls.blk   = block_index;
        cls.word  = word_index;
        cls.data  = data_in;
        cls.check = ST_OK;
        if (!opcode)
        begin
            cls.kind = cfg.on ? KIND_LKP : KIND_LKP_OFF;
        end
        else if (32'(word_index) >= BLOCK_WORDS)
        begin
            cls.kind = KIND_INS_SKIP;
        end
        else if (word_index == '0)
        begin
            cls.kind = KIND_INS_FIRST;
            if (!cfg.on)
            begin
                cls.check = ST_DISABLED;
            end
            else if (32'(disk) >= NUM_DISKS || 32'(block_index) >= BLOCKS_PER_DISK)
            begin
                cls.check = ST_RANGE;
            end
        end
        else
        begin
            cls.kind = KIND_INS_WORD;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/lbc_engine.sv */
module lbc_engine
    import lbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lbc_cfg_t    cfg,
    input  logic        q_empty,
    input  lbc_item_t   q_item,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [63:0] data_out,
    output logic [4:0]  word_out,
    output logic        last,
    output logic [31:0] hit_count,
    output logic [31:0] query_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_TAG, S_VICT, S_PLACE, S_DATA, S_RD, S_EMIT, S_REPLY
    } state_t;

    logic [11:0] tag_mem   [MAX_ENTRIES];
    logic [31:0] stamp_mem [MAX_ENTRIES];
    logic [63:0] data_mem  [MAX_ENTRIES * BLOCK_WORDS];
    logic [11:0] tag_q;
    logic [31:0] stamp_q;
    logic [63:0] data_q;

    logic [ENTRY_W-1:0] tag_raddr, stamp_raddr, tag_waddr, stamp_waddr;
    logic [DADDR_W-1:0] data_raddr, data_waddr;
    logic               tag_we, stamp_we, data_we;
    logic [31:0]        stamp_wdata;

    state_t             state_reg, state_next;
    lbc_item_t          item_reg, item_next;
    logic [CNT_W-1:0]   idx_reg, idx_next, lim_reg, lim_next;
    logic               pend_reg, pend_next;
    logic [ENTRY_W-1:0] pend_idx_reg, pend_idx_next;
    logic [ENTRY_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]        best_stamp_reg, best_stamp_next;
    logic               best_ok_reg, best_ok_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [31:0]        tick_reg, tick_next, hits_reg, hits_next;
    logic [31:0]        queries_reg, queries_next;
    logic [ENTRY_W-1:0] target_reg, target_next, base_reg, base_next;
    status_t            verdict_reg, verdict_next, res_reg, res_next;
    logic [WORD_W-1:0]  k_reg, k_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [63:0]        out_data_reg, out_data_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic               out_last_reg, out_last_next;
    logic [31:0]        out_hits_reg, out_hits_next, out_q_reg, out_q_next;

    logic load_ok, tag_match, is_lookup;

    assign load_ok   = !out_valid_reg || pop;
    assign tag_match = pend_reg && (tag_q == {item_reg.disk, item_reg.blk});
    assign is_lookup = (item_reg.kind == KIND_LKP);

    assign empty       = !out_valid_reg;
    assign status      = out_status_reg;
    assign data_out    = out_data_reg;
    assign word_out    = out_word_reg;
    assign last        = out_last_reg;
    assign hit_count   = out_hits_reg;
    assign query_count = out_q_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_ok_next    = best_ok_reg;
        fill_next       = fill_reg;
        tick_next       = tick_reg;
        hits_next       = hits_reg;
        queries_next    = queries_reg;
        target_next     = target_reg;
        base_next       = base_reg;
        verdict_next    = verdict_reg;
        res_next        = res_reg;
        k_next          = k_reg;
        q_pop           = 1'b0;
        tag_raddr       = idx_reg[ENTRY_W-1:0];
        stamp_raddr     = idx_reg[ENTRY_W-1:0];
        data_raddr      = {base_reg, k_reg};
        tag_we          = 1'b0;
        tag_waddr       = target_reg;
        stamp_we        = 1'b0;
        stamp_waddr     = target_reg;
        stamp_wdata     = tick_reg;
        data_we         = 1'b0;
        data_waddr      = {target_reg, item_reg.word};

        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        out_hits_next   = out_hits_reg;
        out_q_next      = out_q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg.clear)
                begin
                    fill_next = '0;
                end
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    idx_next  = '0;
                    lim_next  = fill_reg;
                    case (q_item.kind)
                        KIND_LKP_OFF:
                        begin
                            res_next   = ST_DISABLED;
                            state_next = S_REPLY;
                        end
                        KIND_LKP:
                        begin
                            queries_next = queries_reg + 32'd1;
                            tick_next    = tick_reg + 32'd1;
                            state_next   = S_TAG;
                        end
                        KIND_INS_FIRST:
                        begin
                            if (q_item.check != ST_OK)
                            begin
                                verdict_next = q_item.check;
                                state_next   = S_DATA;
                            end
                            else
                            begin
                                state_next = S_TAG;
                            end
                        end
                        KIND_INS_WORD:
                        begin
                            state_next = S_DATA;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // one tag read per cycle, compare lands in the cycle after the read
            S_TAG:
            begin
                if (tag_match)
                begin
                    stamp_we    = 1'b1;
                    stamp_waddr = pend_idx_reg;
                    if (is_lookup)
                    begin
                        hits_next  = hits_reg + 32'd1;
                        base_next  = pend_idx_reg;
                        k_next     = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        target_next  = pend_idx_reg;
                        verdict_next = ST_UPDATED;
                        state_next   = S_DATA;
                    end
                end
                else if (idx_reg < lim_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ENTRY_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (is_lookup)
                begin
                    res_next   = ST_MISS;
                    state_next = S_REPLY;
                end
                else
                begin
                    tick_next = tick_reg + 32'd1;
                    if (fill_reg < cfg.cap)
                    begin
                        target_next = fill_reg[ENTRY_W-1:0];
                        fill_next   = fill_reg + 1'b1;
                        state_next  = S_PLACE;
                    end
                    else
                    begin
                        idx_next     = '0;
                        lim_next     = cfg.cap;
                        best_ok_next = 1'b0;
                        state_next   = S_VICT;
                    end
                end
            end

            // oldest stamp, lowest index on a tie
            S_VICT:
            begin
                if (pend_reg && (!best_ok_reg || stamp_q < best_stamp_reg))
                begin
                    best_ok_next    = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_stamp_next = stamp_q;
                end
                if (idx_reg < lim_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ENTRY_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    target_next = best_idx_reg;
                    state_next  = S_PLACE;
                end
            end

            S_PLACE:
            begin
                tag_we       = 1'b1;
                stamp_we     = 1'b1;
                verdict_next = ST_OK;
                state_next   = S_DATA;
            end

            S_DATA:
            begin
                data_we = (verdict_reg == ST_OK) || (verdict_reg == ST_UPDATED);
                if (item_reg.word == LAST_WORD)
                begin
                    res_next   = verdict_reg;
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = data_q;
                    out_word_next   = k_reg;
                    out_last_next   = (k_reg == LAST_WORD);
                    out_hits_next   = hits_reg;
                    out_q_next      = queries_reg;
                    k_next          = k_reg + 1'b1;
                    state_next      = (k_reg == LAST_WORD) ? S_IDLE : S_RD;
                end
            end

            S_REPLY:
            begin
                if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_data_next   = '0;
                    out_word_next   = '0;
                    out_last_next   = 1'b1;
                    out_hits_next   = hits_reg;
                    out_q_next      = queries_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= {item_reg.disk, item_reg.blk};
        end
        tag_q <= tag_mem[tag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        stamp_q <= stamp_mem[stamp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= item_reg.data;
        end
        data_q <= data_mem[data_raddr];
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        idx_reg         <= idx_next;
        lim_reg         <= lim_next;
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_stamp_reg  <= best_stamp_next;
        base_reg        <= base_next;
        res_reg         <= res_next;
        k_reg           <= k_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_word_reg    <= out_word_next;
        out_last_reg    <= out_last_next;
        out_hits_reg    <= out_hits_next;
        out_q_reg       <= out_q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            best_ok_reg   <= 1'b0;
            fill_reg      <= '0;
            tick_reg      <= '0;
            hits_reg      <= '0;
            queries_reg   <= '0;
            target_reg    <= '0;
            verdict_reg   <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            best_ok_reg   <= best_ok_next;
            fill_reg      <= fill_next;
            tick_reg      <= tick_next;
            hits_reg      <= hits_next;
            queries_reg   <= queries_next;
            target_reg    <= target_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/lru_block_cache.sv */
// Fully associative cache of disk blocks (256 entries of 32 x 64-bit words)
// with least-recently-used replacement. Items enter through a two-deep queue
// (push/full) and results leave through an output register (empty/pop), so
// either side can stall freely. A lookup returns 32 word items on a hit
// (last on the final word) or one miss or disabled item; insert words
// return an item only on the last word of the block. Timing is set by
// the tag and stamp memories, which have one read port and are walked
// one entry per cycle: a lookup searches the filled entries, then reads
// and emits each word in turn; the first word of an insert also walks
// the stamps when a victim must be found; other words only write data.
// Registers: 0x0 cache_on, 0x4 entries_in_use (clamped to 2..256). Writing
// either one empties the cache; write them only while the block is idle.
module lru_block_cache
    import lbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [3:0]  disk,
    input  logic [7:0]  block_index,
    input  logic [4:0]  word_index,
    input  logic [63:0] data_in,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [63:0] data_out,
    output logic [4:0]  word_out,
    output logic        last,
    output logic [31:0] hit_count,
    output logic [31:0] query_count
);

    logic       cache_on_reg, cache_on_next;
    logic [8:0] eiu_reg, eiu_next;
    logic       wr_en;
    lbc_cfg_t   cfg;
    logic       q_pop, q_empty;
    lbc_item_t  q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cache_on_next = cache_on_reg;
        eiu_next      = eiu_reg;
        if (wr_en && !paddr[2])
        begin
            cache_on_next = pwdata[0];
        end
        if (wr_en && paddr[2])
        begin
            eiu_next = pwdata[8:0];
        end
    end

    assign prdata = paddr[2] ? {23'd0, eiu_reg} : {31'd0, cache_on_reg};

    // capacity clamp
    always_comb
    begin
        cfg.on    = cache_on_reg;
        cfg.clear = wr_en;
        if (32'(eiu_reg) < MIN_CAP)
        begin
            cfg.cap = CNT_W'(MIN_CAP);
        end
        else if (32'(eiu_reg) > MAX_ENTRIES)
        begin
            cfg.cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cfg.cap = eiu_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_on_reg <= 1'b0;
            eiu_reg      <= 9'd2;
        end
        else
        begin
            cache_on_reg <= cache_on_next;
            eiu_reg      <= eiu_next;
        end
    end

    lbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .disk        (disk),
        .block_index (block_index),
        .word_index  (word_index),
        .data_in     (data_in),
        .q_pop       (q_pop),
        .q_empty     (q_empty),
        .q_item      (q_item)
    );

    lbc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_out    (data_out),
        .word_out    (word_out),
        .last        (last),
        .hit_count   (hit_count),
        .query_count (query_count)
    );

endmodule

/* bench/testbench.sv */
module testbench
    import lbc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // register map
    localparam logic [2:0] REG_ON  = 3'd0;
    localparam logic [2:0] REG_CAP = 3'd4;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    // quiet time before a register write or the end: covers a full victim search
    localparam int SETTLE = 700;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push, full;
    logic        opcode;
    logic [3:0]  disk;
    logic [7:0]  block_index;
    logic [4:0]  word_index;
    logic [63:0] data_in;
    logic        empty, pop;
    logic [2:0]  status;
    logic [63:0] data_out;
    logic [4:0]  word_out;
    logic        last;
    logic [31:0] hit_count, query_count;

    lru_block_cache dut (.*);

    // one expected result item
    typedef struct {
        status_t     st;
        logic [63:0] data;
        logic [4:0]  word;
        logic        last;
        logic [31:0] hits;
        logic [31:0] queries;
    } reply_t;

    reply_t pending_replies[$];

    // shadow of the cache
    logic [3:0]  sh_disk [MAX_ENTRIES];
    logic [7:0]  sh_blk  [MAX_ENTRIES];
    logic [31:0] sh_stamp[MAX_ENTRIES];
    logic [63:0] sh_data [MAX_ENTRIES][BLOCK_WORDS];
    bit          sh_wrote[MAX_ENTRIES][BLOCK_WORDS]; // word ever written
    int unsigned sh_fill, sh_target;
    status_t     sh_verdict;
    logic [31:0] sh_tick, sh_hits, sh_queries;
    logic        sh_on;
    int unsigned sh_cap;

    int  fails;
    int  cycles;
    bit  calm;          // no idling on either side
    bit  pin_on;        // typed-in status overrides the predicted one
    status_t pin_status;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic int find_entry(logic [3:0] d, logic [7:0] b);
        for (int i = 0; i < sh_fill; i++)
            if (sh_disk[i] == d && sh_blk[i] == b)
                return i;
        return -1;
    endfunction

    function automatic void queue_reply(status_t st, logic [63:0] dat,
                                        logic [4:0] w, logic lst);
        reply_t r;
        r.st = pin_on ? pin_status : st;
        r.data = dat;
        r.word = w;
        r.last = lst;
        r.hits = sh_hits;
        r.queries = sh_queries;
        pending_replies.push_back(r);
    endfunction

    // advance the shadow cache by one accepted item, queue what it returns
    function automatic void cache_step(logic op, logic [3:0] d, logic [7:0] b,
                                       logic [4:0] w, logic [63:0] dat);
        int hit;
        int unsigned vic;
        if (op == OP_LOOKUP)
        begin
            if (!sh_on)
            begin
                queue_reply(ST_DISABLED, '0, '0, 1'b1);
                return;
            end
            sh_queries++;
            sh_tick++;
            hit = find_entry(d, b);
            if (hit < 0)
            begin
                queue_reply(ST_MISS, '0, '0, 1'b1);
                return;
            end
            sh_stamp[hit] = sh_tick;
            sh_hits++;
            for (int k = 0; k < BLOCK_WORDS; k++)
                queue_reply(ST_OK, sh_data[hit][k], 5'(k), k == BLOCK_WORDS - 1);
            return;
        end
        if (w == 0)
        begin
            if (!sh_on)
                sh_verdict = ST_DISABLED;
            else if (d >= NUM_DISKS || b >= BLOCKS_PER_DISK)
                sh_verdict = ST_RANGE;
            else
            begin
                hit = find_entry(d, b);
                if (hit >= 0)
                begin
                    sh_target = hit;
                    sh_stamp[hit] = sh_tick;
                    sh_verdict = ST_UPDATED;
                end
                else
                begin
                    sh_tick++;
                    if (sh_fill < sh_cap)
                    begin
                        vic = sh_fill;
                        sh_fill++;
                    end
                    else
                    begin
                        // oldest stamp, lowest index on a tie
                        vic = 0;
                        for (int i = 1; i < sh_cap; i++)
                            if (sh_stamp[i] < sh_stamp[vic])
                                vic = i;
                    end
                    sh_disk[vic] = d;
                    sh_blk[vic] = b;
                    sh_stamp[vic] = sh_tick;
                    sh_target = vic;
                    sh_verdict = ST_OK;
                end
            end
        end
        if (sh_verdict == ST_OK || sh_verdict == ST_UPDATED)
        begin
            sh_data[sh_target][w] = dat;
            sh_wrote[sh_target][w] = 1'b1;
        end
        if (w == LAST_WORD)
            queue_reply(sh_verdict, '0, '0, 1'b1);
    endfunction

    // a lookup that would hit a block with never-written words must not be sent
    function automatic bit lookup_safe(logic [3:0] d, logic [7:0] b);
        int hit;
        hit = sh_on ? find_entry(d, b) : -1;
        if (hit < 0)
            return 1'b1;
        for (int k = 0; k < BLOCK_WORDS; k++)
            if (!sh_wrote[hit][k])
                return 1'b0;
        return 1'b1;
    endfunction

    // one item through push/full; push stays high across back-to-back items
    task automatic send_item(logic op, logic [3:0] d, logic [7:0] b,
                             logic [4:0] w, logic [63:0] dat);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        disk <= d;
        block_index <= b;
        word_index <= w;
        data_in <= dat;
        do
            @(posedge clk);
        while (full);
        cache_step(op, d, b, w, dat);
    endtask

    // whole block, or the first n_words of it
    task automatic send_block(logic [3:0] d, logic [7:0] b, int n_words, int fill_kind);
        logic [63:0] dat;
        for (int w = 0; w < n_words; w++)
        begin
            case (fill_kind)
                1:       dat = '1;
                2:       dat = '0;
                default: dat = {$urandom, $urandom};
            endcase
            // tag of non-first words is ignored: scramble it
            if (w == 0)
                send_item(OP_INSERT, d, b, 5'(w), dat);
            else
                send_item(OP_INSERT, 4'($urandom), 8'($urandom), 5'(w), dat);
        end
    endtask

    // first and last word only: the words between keep what the entry held
    task automatic send_short(logic [3:0] d, logic [7:0] b);
        send_item(OP_INSERT, d, b, 5'd0, {$urandom, $urandom});
        send_item(OP_INSERT, 4'($urandom), 8'($urandom), LAST_WORD, {$urandom, $urandom});
    endtask

    // register write, only once the block has drained
    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        push <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (SETTLE) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_ON)
            sh_on = val[0];
        else
        begin
            sh_cap = val[8:0];
            if (sh_cap < MIN_CAP)
                sh_cap = MIN_CAP;
            if (sh_cap > MAX_ENTRIES)
                sh_cap = MAX_ENTRIES;
        end
        sh_fill = 0;
    endtask

    // result side: check each popped item, stall in short bursts
    initial
    begin
        reply_t want;
        int stall;
        stall = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected result item status %0d", $time, status);
                    fails++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, want.st, status);
                        fails++;
                    end
                    if (data_out !== want.data)
                    begin
                        $display("%0t: data_out exp %h got %h", $time, want.data, data_out);
                        fails++;
                    end
                    if (word_out !== want.word)
                    begin
                        $display("%0t: word_out exp %0d got %0d", $time, want.word, word_out);
                        fails++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last exp %0d got %0d", $time, want.last, last);
                        fails++;
                    end
                    if (hit_count !== want.hits)
                    begin
                        $display("%0t: hit_count exp %0d got %0d", $time, want.hits, hit_count);
                        fails++;
                    end
                    if (query_count !== want.queries)
                    begin
                        $display("%0t: query_count exp %0d got %0d", $time, want.queries,
                                 query_count);
                        fails++;
                    end
                end
            end
            if (calm)
                pop <= 1'b1;
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // directed rows: one operation each
    typedef enum {ROW_LOOKUP, ROW_INSERT, ROW_SHORT, ROW_STRAY, ROW_ON, ROW_CAP} row_kind_t;
    typedef struct {
        row_kind_t   kind;
        logic [3:0]  dsk;
        logic [7:0]  blk;
        int          arg;      // register value, stray word index, or data kind
        bit          typed;
        status_t     want;
    } row_t;

    row_t plan[] = '{
        // disabled after reset: both sides refused
        '{ROW_LOOKUP, 4'd0,  8'd0,   0, 1'b1, ST_DISABLED},
        '{ROW_SHORT,  4'd0,  8'd0,   0, 1'b1, ST_DISABLED},
        '{ROW_ON,     4'd0,  8'd0,   1, 1'b0, ST_OK},
        '{ROW_CAP,    4'd0,  8'd0,   2, 1'b0, ST_OK},
        '{ROW_LOOKUP, 4'd0,  8'd0,   0, 1'b1, ST_MISS},
        '{ROW_INSERT, 4'd0,  8'd0,   1, 1'b1, ST_OK},
        '{ROW_INSERT, 4'd15, 8'd255, 2, 1'b1, ST_OK},
        '{ROW_LOOKUP, 4'd0,  8'd0,   0, 1'b0, ST_OK},
        // full at capacity 2: least recent (15/255) goes
        '{ROW_SHORT,  4'd1,  8'd7,   0, 1'b1, ST_OK},
        '{ROW_LOOKUP, 4'd15, 8'd255, 0, 1'b1, ST_MISS},
        '{ROW_SHORT,  4'd0,  8'd0,   0, 1'b1, ST_UPDATED},
        '{ROW_LOOKUP, 4'd0,  8'd0,   0, 1'b0, ST_OK},
        '{ROW_LOOKUP, 4'd1,  8'd7,   0, 1'b0, ST_OK},
        // last word with no first word: reuses the stored verdict
        '{ROW_STRAY,  4'd9,  8'd9,  31, 1'b1, ST_UPDATED},
        '{ROW_STRAY,  4'd9,  8'd9,   5, 1'b0, ST_OK},
        '{ROW_CAP,    4'd0,  8'd0, 511, 1'b0, ST_OK},
        '{ROW_LOOKUP, 4'd0,  8'd0,   0, 1'b1, ST_MISS},
        '{ROW_ON,     4'd0,  8'd0,   0, 1'b0, ST_OK},
        '{ROW_STRAY,  4'd0,  8'd0,  31, 1'b0, ST_OK}
    };

    task automatic run_row(row_t r);
        pin_on = r.typed;
        pin_status = r.want;
        case (r.kind)
            ROW_LOOKUP: send_item(OP_LOOKUP, r.dsk, r.blk, 5'($urandom), {$urandom, $urandom});
            ROW_INSERT: send_block(r.dsk, r.blk, BLOCK_WORDS, r.arg);
            ROW_SHORT:  send_short(r.dsk, r.blk);
            ROW_STRAY:  send_item(OP_INSERT, r.dsk, r.blk, 5'(r.arg), {$urandom, $urandom});
            ROW_ON:     write_reg(REG_ON, 32'(r.arg));
            ROW_CAP:    write_reg(REG_CAP, 32'(r.arg));
            default:    $display("%0t: unknown row kind", $time);
        endcase
        pin_on = 1'b0;
    endtask

    // small tag pool so hits, updates and evictions happen often
    task automatic pick_tag(output logic [3:0] d, output logic [7:0] b);
        case ($urandom_range(0, 3))
            0:       d = 4'd0;
            1:       d = 4'd15;
            default: d = 4'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 4))
            0:       b = 8'd255;
            1:       b = 8'($urandom);
            default: b = 8'($urandom_range(0, 3));
        endcase
    endtask

    task automatic random_ops(int n_ops);
        logic [3:0] d;
        logic [7:0] b;
        int pick;
        for (int i = 0; i < n_ops; i++)
        begin
            pick_tag(d, b);
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                if (lookup_safe(d, b))
                    send_item(OP_LOOKUP, d, b, 5'($urandom), {$urandom, $urandom});
            end
            else if (pick < 8)
                send_short(d, b);
            else if (pick == 8)
                send_block(d, b, $urandom_range(1, 3), 0);   // broken off
            else
                send_item(OP_INSERT, d, b, 5'($urandom_range(1, 31)), {$urandom, $urandom});
        end
    endtask

    int caps[] = '{3, 2, 0, 256, 5, 511};

    initial
    begin
        fails = 0;
        calm = 1'b0;
        pin_on = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        opcode = OP_LOOKUP;
        disk = '0;
        block_index = '0;
        word_index = '0;
        data_in = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            sh_disk[i] = '0;
            sh_blk[i] = '0;
            sh_stamp[i] = '0;
            for (int k = 0; k < BLOCK_WORDS; k++)
            begin
                sh_data[i][k] = '0;
                sh_wrote[i][k] = 1'b0;
            end
        end
        sh_fill = 0;
        sh_target = 0;
        sh_verdict = ST_OK;
        sh_tick = '0;
        sh_hits = '0;
        sh_queries = '0;
        sh_on = 1'b0;
        sh_cap = MIN_CAP;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            run_row(plan[i]);

        // random phases across capacities; one short disabled phase
        foreach (caps[i])
        begin
            write_reg(REG_ON, 32'(i != 4));
            write_reg(REG_CAP, 32'(caps[i]));
            if (i == caps.size() - 1)
                calm = 1'b1;
            random_ops(i == 4 ? 2 : 4);
        end
        push <= 1'b0;

        wait (pending_replies.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/lbc_pkg.sv
sv/lbc_front.sv
sv/lbc_engine.sv
sv/lru_block_cache.sv
bench/testbench.sv
